// ===== design/priority_process_scheduler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority process scheduler
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PROCESS_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_PROCESS_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler port check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler port check failed (next cycle)");

`endif

// ===== design/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority process scheduler package
// Field widths, status and command codes, and the types shared by the
// queue cells, the queue chains and the controller.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int ID_W       = 4;
   localparam int PRIO_W     = 4;
   localparam int TIME_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int NUM_IDS    = 2 ** ID_W;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_LOADED     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

   // One queue slot: a process identifier and its current priority.
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } cell_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_UPDATE,
      OP_INSERT,
      OP_PUSH,
      OP_POP
   } cell_op_type;

   // Command broadcast to every cell of one chain.
   typedef struct packed {
      cell_op_type       op;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } chain_cmd_type;

endpackage

// ===== design/pps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler queue cell
// Holds one queue slot and decides, from its own contents and those of its
// neighbors, what the slot holds after the broadcast command.
// ----------------------------------------------------------------------------
module pps_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  pps_pkg::chain_cmd_type cmd,
   input  pps_pkg::cell_type      left_cell,
   input  logic                   left_ge,
   input  pps_pkg::cell_type      right_cell,
   output pps_pkg::cell_type      cell_q,
   output logic                   ge
);

   pps_pkg::cell_type cell_ff;
   pps_pkg::cell_type cell_in;
   pps_pkg::cell_type new_cell;

   assign new_cell = '{valid: 1'b1, id: cmd.id, prio: cmd.prio};

   // A cell stays ahead of the new entry only while it and every cell in front
   // of it hold an equal or higher priority; a reload can leave the list unsorted.
   assign ge = left_ge && cell_ff.valid && (cell_ff.prio >= cmd.prio);

   always_comb begin
      cell_in = cell_ff;
      case (cmd.op)
         pps_pkg::OP_UPDATE: begin
            if (cell_ff.valid && (cell_ff.id == cmd.id)) begin
               cell_in.prio = cmd.prio;
            end
         end
         pps_pkg::OP_INSERT: begin
            // The new entry lands behind the leading run of entries of equal or higher priority.
            if (!ge) begin
               cell_in = left_ge ? new_cell : left_cell;
            end
         end
         pps_pkg::OP_PUSH: begin
            if (!cell_ff.valid && left_cell.valid) begin
               cell_in = new_cell;
            end
         end
         pps_pkg::OP_POP: begin
            cell_in = right_cell;
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;

endmodule

// ===== design/pps_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler queue chain
// A row of queue cells with the head at cell zero; serves as the sorted
// ready list or the FIFO waiting list depending on the commands it gets.
// ----------------------------------------------------------------------------
module pps_chain #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pps_pkg::chain_cmd_type cmd,
   output pps_pkg::cell_type      head
);

   pps_pkg::cell_type cells [DEPTH];
   logic              ge    [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pps_pkg::cell_type left_cell;
      pps_pkg::cell_type right_cell;
      logic              left_ge;

      if (i == 0) begin : g_first
         // The space in front of the head acts as a full, higher-ranked slot.
         assign left_cell = '{valid: 1'b1, id: '0, prio: '0};
         assign left_ge   = 1'b1;
      end else begin : g_inner
         assign left_cell = cells[i-1];
         assign left_ge   = ge[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_cell = '0;
      end else begin : g_body
         assign right_cell = cells[i+1];
      end

      pps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_cell  (left_cell),
         .left_ge    (left_ge),
         .right_cell (right_cell),
         .cell_q     (cells[i]),
         .ge         (ge[i])
      );
   end

   assign head = cells[0];

endmodule

// ===== design/priority_process_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Sequence: a load passes through ST_LOAD and ST_ENQ (only ST_LOAD when the table is full)
// before ST_DONE; a step passes through ST_POP, ST_WAKE when a process is woken, and
// ST_REQUEUE (only ST_POP on an empty ready list). ST_DONE holds the result longer while
// a result waits unclaimed; a new request is taken only once the result is presented.
// Reset (synchronous, active high) empties both lists and clears the handshakes.
// ----------------------------------------------------------------------------
// Priority process scheduler
// Keeps a priority-sorted ready list and a FIFO waiting list in two chains of
// cells, loads processes and runs scheduling steps with time slices.
// ----------------------------------------------------------------------------
module priority_process_scheduler_unit #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] process_id, [7:4] process_priority, [8] starts_waiting,
   // [24:9] needed_time, [25] wake_request, [41:26] slice_time,
   // [42] requeue_to_waiting, [47:43] zero
   input  logic [pps_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] command
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] ran_id, [7:4] ran_priority, [8] finished, [24:9] time_left,
   // [25] woke_one, [31:26] zero
   output logic [pps_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [pps_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int CW = $clog2(MAX_PROCESSES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ENQ,
      ST_POP,
      ST_WAKE,
      ST_REQUEUE,
      ST_DONE
   } state_type;

   state_type state_ff;

   // Captured request fields.
   logic [pps_pkg::ID_W-1:0]   pid_ff;
   logic [pps_pkg::PRIO_W-1:0] prio_ff;
   logic                       starts_waiting_ff;
   logic [pps_pkg::TIME_W-1:0] needed_ff;
   logic                       wake_ff;
   logic [pps_pkg::TIME_W-1:0] slice_ff;
   logic                       to_waiting_ff;

   // Result being built.
   logic [pps_pkg::STATUS_W-1:0] res_status_ff;
   logic [pps_pkg::ID_W-1:0]     res_id_ff;
   logic [pps_pkg::PRIO_W-1:0]   res_prio_ff;
   logic                         res_finished_ff;
   logic [pps_pkg::TIME_W-1:0]   res_left_ff;
   logic                         res_woke_ff;

   // Output register.
   logic                         rsp_valid_ff;
   logic [pps_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [pps_pkg::ID_W-1:0]     rsp_id_ff;
   logic [pps_pkg::PRIO_W-1:0]   rsp_prio_ff;
   logic                         rsp_finished_ff;
   logic [pps_pkg::TIME_W-1:0]   rsp_left_ff;
   logic                         rsp_woke_ff;

   logic [CW-1:0] ready_count_ff;
   logic [CW-1:0] waiting_count_ff;

   logic [pps_pkg::TIME_W-1:0] remaining_ff [pps_pkg::NUM_IDS];
   logic                       rem_we;
   logic [pps_pkg::ID_W-1:0]   rem_addr;
   logic [pps_pkg::TIME_W-1:0] rem_in;

   pps_pkg::chain_cmd_type ready_cmd;
   pps_pkg::chain_cmd_type waiting_cmd;
   pps_pkg::cell_type      ready_head;
   pps_pkg::cell_type      waiting_head;

   logic                       table_full;
   logic [pps_pkg::TIME_W-1:0] rem_rd;
   logic                       slice_exceeds;
   logic [pps_pkg::TIME_W-1:0] rem_after;
   logic                       req_accept;
   logic                       rsp_slot_free;

   assign req_tready    = (state_ff == ST_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;

   assign table_full = ({1'b0, ready_count_ff} + {1'b0, waiting_count_ff})
                       >= (CW + 1)'(MAX_PROCESSES);

   assign rem_rd        = remaining_ff[ready_head.id];
   assign slice_exceeds = slice_ff > rem_rd;
   assign rem_after     = slice_exceeds ? '0 : (rem_rd - slice_ff);

   pps_chain #(.DEPTH(MAX_PROCESSES)) u_ready (
      .clock (clock),
      .reset (reset),
      .cmd   (ready_cmd),
      .head  (ready_head)
   );

   pps_chain #(.DEPTH(MAX_PROCESSES)) u_waiting (
      .clock (clock),
      .reset (reset),
      .cmd   (waiting_cmd),
      .head  (waiting_head)
   );

   // List commands for the current step of the sequence.
   always_comb begin
      ready_cmd   = '{op: pps_pkg::OP_HOLD, id: pid_ff, prio: prio_ff};
      waiting_cmd = '{op: pps_pkg::OP_HOLD, id: pid_ff, prio: prio_ff};
      rem_we      = 1'b0;
      rem_addr    = pid_ff;
      rem_in      = needed_ff;
      case (state_ff)
         ST_LOAD: begin
            if (!table_full) begin
               // A reload retags every queued copy of the identifier.
               ready_cmd.op   = pps_pkg::OP_UPDATE;
               waiting_cmd.op = pps_pkg::OP_UPDATE;
               rem_we         = 1'b1;
            end
         end
         ST_ENQ: begin
            if (starts_waiting_ff) begin
               waiting_cmd.op = pps_pkg::OP_PUSH;
            end else begin
               ready_cmd.op = pps_pkg::OP_INSERT;
            end
         end
         ST_POP: begin
            if (ready_head.valid) begin
               ready_cmd.op = pps_pkg::OP_POP;
               rem_we       = 1'b1;
               rem_addr     = ready_head.id;
               rem_in       = rem_after;
            end
         end
         ST_WAKE: begin
            waiting_cmd.op = pps_pkg::OP_POP;
            ready_cmd      = '{op: pps_pkg::OP_INSERT, id: waiting_head.id,
                               prio: waiting_head.prio};
         end
         ST_REQUEUE: begin
            if (!res_finished_ff) begin
               if (to_waiting_ff) begin
                  waiting_cmd = '{op: pps_pkg::OP_PUSH, id: res_id_ff, prio: res_prio_ff};
               end else begin
                  ready_cmd = '{op: pps_pkg::OP_INSERT, id: res_id_ff, prio: res_prio_ff};
               end
            end
         end
         default: begin
            rem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         remaining_ff[rem_addr] <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         ready_count_ff   <= '0;
         waiting_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // In ST_DONE the output register is reloaded whenever it is claimed.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  pid_ff            <= req_tdata[3:0];
                  prio_ff           <= req_tdata[7:4];
                  starts_waiting_ff <= req_tdata[8];
                  needed_ff         <= req_tdata[24:9];
                  wake_ff           <= req_tdata[25];
                  slice_ff          <= req_tdata[41:26];
                  to_waiting_ff     <= req_tdata[42];
                  state_ff <= (req_tuser == pps_pkg::CMD_STEP) ? ST_POP : ST_LOAD;
               end
            end
            ST_LOAD: begin
               res_id_ff       <= '0;
               res_prio_ff     <= '0;
               res_finished_ff <= 1'b0;
               res_left_ff     <= '0;
               res_woke_ff     <= 1'b0;
               if (table_full) begin
                  res_status_ff <= pps_pkg::STATUS_FULL;
                  state_ff      <= ST_DONE;
               end else begin
                  res_status_ff <= pps_pkg::STATUS_LOADED;
                  state_ff      <= ST_ENQ;
               end
            end
            ST_ENQ: begin
               if (starts_waiting_ff) begin
                  waiting_count_ff <= waiting_count_ff + CW'(1);
               end else begin
                  ready_count_ff <= ready_count_ff + CW'(1);
               end
               state_ff <= ST_DONE;
            end
            ST_POP: begin
               res_woke_ff <= 1'b0;
               if (!ready_head.valid) begin
                  res_status_ff   <= pps_pkg::STATUS_EMPTY;
                  res_id_ff       <= '0;
                  res_prio_ff     <= '0;
                  res_finished_ff <= 1'b0;
                  res_left_ff     <= '0;
                  state_ff        <= ST_DONE;
               end else begin
                  res_status_ff   <= pps_pkg::STATUS_DISPATCHED;
                  res_id_ff       <= ready_head.id;
                  res_prio_ff     <= ready_head.prio;
                  res_finished_ff <= slice_exceeds;
                  res_left_ff     <= rem_after;
                  ready_count_ff  <= ready_count_ff - CW'(1);
                  if (wake_ff && (waiting_count_ff != '0)) begin
                     state_ff <= ST_WAKE;
                  end else begin
                     state_ff <= ST_REQUEUE;
                  end
               end
            end
            ST_WAKE: begin
               waiting_count_ff <= waiting_count_ff - CW'(1);
               ready_count_ff   <= ready_count_ff + CW'(1);
               res_woke_ff      <= 1'b1;
               state_ff         <= ST_REQUEUE;
            end
            ST_REQUEUE: begin
               if (!res_finished_ff) begin
                  if (to_waiting_ff) begin
                     waiting_count_ff <= waiting_count_ff + CW'(1);
                  end else begin
                     ready_count_ff <= ready_count_ff + CW'(1);
                  end
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // Wait here only while the previous result is still unclaimed.
               if (rsp_slot_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= res_status_ff;
                  rsp_id_ff       <= res_id_ff;
                  rsp_prio_ff     <= res_prio_ff;
                  rsp_finished_ff <= res_finished_ff;
                  rsp_left_ff     <= res_left_ff;
                  rsp_woke_ff     <= res_woke_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_woke_ff, rsp_left_ff, rsp_finished_ff,
                        rsp_prio_ff, rsp_id_ff};

endmodule

// ===== design/pps_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority process scheduler port checker
// Watches the request and response ports of the scheduler over time and is
// bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_process_scheduler_unit_assert.svh"

module pps_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [pps_pkg::STATUS_W-1:0]   rsp_tuser
);

   // A stalled response keeps its contents.
   `PPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Loads, rejections and empty steps carry no dispatch information.
   `PPS_ASSERT_IMPL(a_no_dispatch_zero, clock, reset, rsp_tvalid && (rsp_tuser != pps_pkg::STATUS_DISPATCHED), rsp_tdata == '0)

   // A finished process reports no remaining time.
   `PPS_ASSERT_IMPL(a_finished_left, clock, reset, rsp_tvalid && (rsp_tuser == pps_pkg::STATUS_DISPATCHED) && rsp_tdata[8], rsp_tdata[24:9] == 16'h0)

   // One transaction is worked on at a time.
   `PPS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind priority_process_scheduler_unit pps_chk u_pps_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
